FILE: hdl/round_robin_task_scheduler_defines.svh
// Assertion macros for the scheduler.
// Both take a label, clock, reset, a condition and a consequence.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// consequence holds in the same cycle as the condition
`define RRTS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// consequence holds in the cycle after the condition
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`else

`define RRTS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/rrts_pkg.sv
`default_nettype none

package rrts_pkg;

   localparam int MAX_TASKS  = 16;
   localparam int EVENT_BITS = 8;
   localparam int ID_SPACE   = 16;
   localparam int ID_W       = 4;
   localparam int OP_W       = 3;
   localparam int ERR_W      = 2;
   localparam int EVENT_W    = 8;
   localparam int SLOT_W     = $clog2(MAX_TASKS);
   localparam int CNT_W      = $clog2(MAX_TASKS + 1);

   localparam logic [ID_W-1:0] IDLE_ID = '0;

   typedef enum logic [1:0] {
      ST_READY   = 2'd0,
      ST_RUNNING = 2'd1,
      ST_WAITING = 2'd2,
      ST_IDLE    = 2'd3
   } status_type;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE = 3'd0,
      OP_END    = 3'd1,
      OP_TICK   = 3'd2,
      OP_WAIT   = 3'd3,
      OP_NOTIFY = 3'd4
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK       = 2'd0,
      ERR_FULL     = 2'd1,
      ERR_UNKNOWN  = 2'd2,
      ERR_IDLE_END = 2'd3
   } err_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [ID_W-1:0]    proc_id;
      logic [EVENT_W-1:0] event_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]  current_id;
      logic             switched;
      logic [ID_W-1:0]  new_id;
      logic [ERR_W-1:0] error;
   } rsp_type;

   // sequencer -> task list
   typedef struct packed {
      logic [SLOT_W-1:0]     ptr;
      logic                  wr_status;
      status_type            status;
      logic                  wr_evt;
      logic [EVENT_BITS-1:0] evt;
      logic                  append;
      logic [ID_W-1:0]       append_id;
      logic                  remove;
   } lst_cmd_type;

   // task list -> sequencer, entry at ptr plus list summary
   typedef struct packed {
      logic [ID_W-1:0]       task_id;
      status_type            status;
      logic [EVENT_BITS-1:0] evt;
      logic [CNT_W-1:0]      count;
      logic [ID_SPACE-1:0]   ids;
   } lst_view_type;

endpackage

`default_nettype wire

FILE: hdl/rrts_task_list.sv
`default_nettype none

`include "round_robin_task_scheduler_defines.svh"

module rrts_task_list import rrts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  lst_cmd_type  lst_cmd,
   output lst_view_type lst_view
);

   logic [ID_W-1:0]       slot_task_ff   [MAX_TASKS];
   logic [ID_W-1:0]       slot_task_in   [MAX_TASKS];
   status_type            slot_status_ff [MAX_TASKS];
   status_type            slot_status_in [MAX_TASKS];
   logic [EVENT_BITS-1:0] slot_event_ff  [MAX_TASKS];
   logic [EVENT_BITS-1:0] slot_event_in  [MAX_TASKS];
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ID_SPACE-1:0]   ids_ff, ids_in;
   logic [SLOT_W-1:0]     tail_slot;
   logic [SLOT_W-1:0]     append_slot;

   // valid entries are always a prefix of count_ff slots
   assign tail_slot   = SLOT_W'(count_ff - CNT_W'(1));
   assign append_slot = count_ff[SLOT_W-1:0];

   always_comb begin
      slot_task_in   = slot_task_ff;
      slot_status_in = slot_status_ff;
      slot_event_in  = slot_event_ff;
      count_in       = count_ff;
      ids_in         = ids_ff;
      if (lst_cmd.remove) begin
         // close the gap, keeping list order
         for (int i = 0; i < MAX_TASKS - 1; i++) begin
            if (SLOT_W'(i) >= lst_cmd.ptr && SLOT_W'(i) < tail_slot) begin
               slot_task_in[i]   = slot_task_ff[i + 1];
               slot_status_in[i] = slot_status_ff[i + 1];
               slot_event_in[i]  = slot_event_ff[i + 1];
            end
         end
         slot_task_in[tail_slot]             = '0;
         slot_status_in[tail_slot]           = ST_READY;
         count_in                            = count_ff - CNT_W'(1);
         ids_in[slot_task_ff[lst_cmd.ptr]]   = 1'b0;
      end else if (lst_cmd.append) begin
         slot_task_in[append_slot]   = lst_cmd.append_id;
         slot_status_in[append_slot] = ST_READY;
         slot_event_in[append_slot]  = '0;
         count_in                    = count_ff + CNT_W'(1);
         ids_in[lst_cmd.append_id]   = 1'b1;
      end else begin
         if (lst_cmd.wr_status) begin
            slot_status_in[lst_cmd.ptr] = lst_cmd.status;
         end
         if (lst_cmd.wr_evt) begin
            slot_event_in[lst_cmd.ptr] = lst_cmd.evt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            slot_task_ff[i]   <= '0;
            slot_status_ff[i] <= (i == 0) ? ST_IDLE : ST_READY;
         end
         count_ff <= CNT_W'(1);
         ids_ff   <= ID_SPACE'(1);
      end else begin
         slot_task_ff   <= slot_task_in;
         slot_status_ff <= slot_status_in;
         count_ff       <= count_in;
         ids_ff         <= ids_in;
      end
   end

   // awaited events are only read for waiting entries, which wrote them
   always_ff @(posedge clock) begin
      slot_event_ff <= slot_event_in;
   end

   assign lst_view.task_id = slot_task_ff[lst_cmd.ptr];
   assign lst_view.status  = slot_status_ff[lst_cmd.ptr];
   assign lst_view.evt     = slot_event_ff[lst_cmd.ptr];
   assign lst_view.count   = count_ff;
   assign lst_view.ids     = ids_ff;

   `RRTS_ASSERT_IMPLIES(a_idle_slot_kept, clock, reset, 1'b1, slot_task_ff[0] == IDLE_ID && slot_status_ff[0] == ST_IDLE && ids_ff[0])
   `RRTS_ASSERT_IMPLIES(a_ids_match_count, clock, reset, 1'b1, $countones(ids_ff) == int'(count_ff))

endmodule

`default_nettype wire

FILE: hdl/rrts_sequencer.sv
`default_nettype none

`include "round_robin_task_scheduler_defines.svh"

module rrts_sequencer import rrts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_payload,
   output lst_cmd_type  lst_cmd,
   input  lst_view_type lst_view
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FREE,
      S_FIND,
      S_PREP,
      S_PICK,
      S_NOTIFY,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [ID_W-1:0]       pid_ff, pid_in;
   logic [EVENT_BITS-1:0] evt_ff, evt_in;
   logic [ID_W-1:0]       before_ff, before_in;
   logic [ID_W-1:0]       running_ff, running_in;
   logic [SLOT_W-1:0]     cur_slot_ff, cur_slot_in;
   logic [SLOT_W-1:0]     ptr_ff, ptr_in;
   logic [CNT_W-1:0]      left_ff, left_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [ID_W-1:0]       new_id_ff, new_id_in;
   err_type               err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [SLOT_W-1:0]     last_slot;
   logic                  at_last;
   logic [SLOT_W-1:0]     next_ptr;
   op_type                req_op;

   assign last_slot = SLOT_W'(lst_view.count - CNT_W'(1));
   assign at_last   = (ptr_ff == last_slot);
   assign next_ptr  = at_last ? '0 : ptr_ff + SLOT_W'(1);
   assign req_op    = op_type'(req_payload.op);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pid_in       = pid_ff;
      evt_in       = evt_ff;
      before_in    = before_ff;
      running_in   = running_ff;
      cur_slot_in  = cur_slot_ff;
      ptr_in       = ptr_ff;
      left_in      = left_ff;
      id_in        = id_ff;
      new_id_in    = new_id_ff;
      err_in       = err_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      lst_cmd      = '0;
      lst_cmd.ptr  = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               pid_in    = req_payload.proc_id;
               evt_in    = req_payload.event_id[EVENT_BITS-1:0];
               before_in = running_ff;
               new_id_in = '0;
               err_in    = ERR_OK;
               ptr_in    = '0;
               id_in     = '0;
               unique case (req_op) inside
                  OP_CREATE: begin
                     if (lst_view.count == CNT_W'(MAX_TASKS)) begin
                        err_in   = ERR_FULL;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_FREE;
                     end
                  end
                  OP_END: begin
                     if (req_payload.proc_id == IDLE_ID) begin
                        err_in   = ERR_IDLE_END;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_FIND;
                     end
                  end
                  OP_TICK, OP_WAIT: begin
                     ptr_in   = cur_slot_ff;
                     state_in = S_PREP;
                  end
                  OP_NOTIFY: state_in = S_NOTIFY;
                  default:   state_in = S_DONE;
               endcase
            end
         end

         // lowest free identifier, one per cycle
         S_FREE: begin
            if (!lst_view.ids[id_ff]) begin
               lst_cmd.append    = 1'b1;
               lst_cmd.append_id = id_ff;
               new_id_in         = id_ff;
               state_in          = S_DONE;
            end else if (id_ff == ID_W'(ID_SPACE - 1)) begin
               err_in   = ERR_FULL;
               state_in = S_DONE;
            end else begin
               id_in = id_ff + ID_W'(1);
            end
         end

         S_FIND: begin
            if (lst_view.task_id == pid_ff) begin
               lst_cmd.remove = 1'b1;
               if (pid_ff == running_ff) begin
                  // resume at the follower of the removed entry
                  ptr_in   = at_last ? '0 : ptr_ff;
                  left_in  = lst_view.count - CNT_W'(1);
                  state_in = S_PICK;
               end else begin
                  if (ptr_ff < cur_slot_ff) begin
                     cur_slot_in = cur_slot_ff - SLOT_W'(1);
                  end
                  state_in = S_DONE;
               end
            end else if (at_last) begin
               err_in   = ERR_UNKNOWN;
               state_in = S_DONE;
            end else begin
               ptr_in = ptr_ff + SLOT_W'(1);
            end
         end

         S_PREP: begin
            if (op_ff == OP_WAIT) begin
               if (lst_view.status != ST_IDLE) begin
                  lst_cmd.wr_status = 1'b1;
                  lst_cmd.status    = ST_WAITING;
                  lst_cmd.wr_evt    = 1'b1;
                  lst_cmd.evt       = evt_ff;
               end
            end else if (lst_view.status == ST_RUNNING) begin
               lst_cmd.wr_status = 1'b1;
               lst_cmd.status    = ST_READY;
            end
            ptr_in   = next_ptr;
            left_in  = lst_view.count;
            state_in = S_PICK;
         end

         S_PICK: begin
            if (lst_view.status == ST_READY) begin
               lst_cmd.wr_status = 1'b1;
               lst_cmd.status    = ST_RUNNING;
               running_in        = lst_view.task_id;
               cur_slot_in       = ptr_ff;
               state_in          = S_DONE;
            end else if (left_ff == CNT_W'(1)) begin
               // nothing ready: idle task at the head
               running_in  = IDLE_ID;
               cur_slot_in = '0;
               state_in    = S_DONE;
            end else begin
               left_in = left_ff - CNT_W'(1);
               ptr_in  = next_ptr;
            end
         end

         S_NOTIFY: begin
            if (lst_view.status == ST_WAITING && lst_view.evt == evt_ff) begin
               lst_cmd.wr_status = 1'b1;
               lst_cmd.status    = ST_READY;
            end
            if (at_last) begin
               state_in = S_DONE;
            end else begin
               ptr_in = ptr_ff + SLOT_W'(1);
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.current_id = running_ff;
               rsp_in.switched   = (running_ff != before_ff);
               rsp_in.new_id     = new_id_ff;
               rsp_in.error      = err_ff;
               state_in          = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         running_ff   <= IDLE_ID;
         cur_slot_ff  <= '0;
         ptr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         running_ff   <= running_in;
         cur_slot_ff  <= cur_slot_in;
         ptr_ff       <= ptr_in;
      end
      op_ff     <= op_in;
      pid_ff    <= pid_in;
      evt_ff    <= evt_in;
      before_ff <= before_in;
      left_ff   <= left_in;
      id_ff     <= id_in;
      new_id_ff <= new_id_in;
      err_ff    <= err_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `RRTS_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && req_ready, !req_ready)
   `RRTS_ASSERT_IMPLIES(a_cur_in_list, clock, reset, state_ff == S_IDLE, CNT_W'(cur_slot_ff) < lst_view.count)
   `RRTS_ASSERT_IMPLIES(a_idle_at_head, clock, reset, state_ff == S_IDLE && running_ff == IDLE_ID, cur_slot_ff == '0)

endmodule

`default_nettype wire

FILE: hdl/round_robin_task_scheduler.sv
`default_nettype none

// Channel  Dir  Handshake              Payload (rrts_pkg)
// req      in   req_valid, req_ready   req_type: op, proc_id, event_id
// rsp      out  rsp_valid, rsp_ready   rsp_type: current_id, switched, new_id, error
//
// Path from request transfer to result loaded: create goes direct when full,
//   else through the free-id scan; end goes direct for the idle task, else find,
//   then a round-robin search if it was current; tick and wait run the search;
//   notify scans every task in the list; unknown op goes direct. One slot per
//   cycle goes through the single compare unit in the sequencer.
// Reset (synchronous) leaves the idle task alone in slot 0, current; no sweep.
// A result not yet taken does not block the next request transfer; that
//   request is held in its final step, not ready, until the output register
//   is free.

module round_robin_task_scheduler import rrts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   lst_cmd_type  lst_cmd;
   lst_view_type lst_view;

   // ordered task list: ids, status, awaited events, id-in-use mask
   rrts_task_list u_task_list (
      .clock    (clock),
      .reset    (reset),
      .lst_cmd  (lst_cmd),
      .lst_view (lst_view)
   );

   // op decode, slot-by-slot scans, round-robin pick, result register
   rrts_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .lst_cmd     (lst_cmd),
      .lst_view    (lst_view)
   );

endmodule

`default_nettype wire

FILE: tb/round_robin_task_scheduler_tb.sv
module round_robin_task_scheduler_tb;
   import rrts_pkg::*;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   always #10 clock = ~clock;

   round_robin_task_scheduler u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // ---------------------------------------------------------------------
   // Shadow copy of the task list, kept in step with every accepted request.
   // Valid entries always form a prefix, so a count stands in for the
   // per-slot valid bits.
   // ---------------------------------------------------------------------
   logic [ID_W-1:0]       slot_id    [MAX_TASKS];
   status_type            slot_state [MAX_TASKS];
   logic [EVENT_BITS-1:0] slot_evt   [MAX_TASKS];
   int                    task_count;
   logic [ID_SPACE-1:0]   used_ids;
   logic [ID_W-1:0]       current_task;

   // one expected result per accepted request, oldest first
   rsp_type sched_expected[$];

   int fail_count;
   int mismatch_reports;

   // handshake shaping, set by the test tasks and the run sequence
   bit sender_idles;
   bit receiver_idles;
   int hold_off_cycles;

   // events that waits use most of the time, so that notifies find waiters
   logic [EVENT_W-1:0] event_pool[4] = '{8'h00, 8'h5A, 8'hA5, 8'hFF};

   task automatic clear_task_list();
      for (int i = 0; i < MAX_TASKS; i++) begin
         slot_id[i]    = '0;
         slot_state[i] = ST_READY;
         slot_evt[i]   = '0;
      end
      slot_state[0] = ST_IDLE;
      task_count    = 1;
      used_ids      = ID_SPACE'(1);
      current_task  = IDLE_ID;
   endtask

   function automatic int slot_of(logic [ID_W-1:0] id);
      for (int i = 0; i < task_count; i++)
         if (slot_id[i] == id)
            return i;
      return -1;
   endfunction

   // Round-robin search over cnt entries from slot first, wrapping; the first
   // ready entry becomes running and current, else the idle task takes over.
   function automatic void reschedule(int first, int cnt);
      int p;
      for (int k = 0; k < cnt; k++) begin
         p = (first + k) % cnt;
         if (slot_state[p] == ST_READY) begin
            slot_state[p] = ST_RUNNING;
            current_task  = slot_id[p];
            return;
         end
      end
      current_task = slot_id[0];
   endfunction

   function automatic rsp_type predict_schedule(req_type r);
      rsp_type               res;
      logic [ID_W-1:0]       prev_task;
      logic [EVENT_BITS-1:0] ev;
      int                    cur;
      int                    at;
      int                    free_id;
      res       = '0;
      prev_task = current_task;
      ev        = r.event_id[EVENT_BITS-1:0];
      cur       = slot_of(current_task);
      if (cur < 0)
         cur = 0;
      case (r.op)
         OP_CREATE: begin
            free_id = 0;
            while (free_id < ID_SPACE && used_ids[free_id])
               free_id++;
            if (free_id >= ID_SPACE || task_count >= MAX_TASKS) begin
               res.error = ERR_FULL;
            end else begin
               slot_id[task_count]    = ID_W'(free_id);
               slot_state[task_count] = ST_READY;
               slot_evt[task_count]   = '0;
               task_count++;
               used_ids[free_id] = 1'b1;
               res.new_id        = ID_W'(free_id);
            end
         end
         OP_END: begin
            at = slot_of(r.proc_id);
            if (r.proc_id == IDLE_ID) begin
               res.error = ERR_IDLE_END;
            end else if (at < 0) begin
               res.error = ERR_UNKNOWN;
            end else begin
               // close the gap, keeping list order
               for (int i = at; i + 1 < task_count; i++) begin
                  slot_id[i]    = slot_id[i+1];
                  slot_state[i] = slot_state[i+1];
                  slot_evt[i]   = slot_evt[i+1];
               end
               task_count--;
               slot_id[task_count]    = '0;
               slot_state[task_count] = ST_READY;
               slot_evt[task_count]   = '0;
               used_ids[r.proc_id]    = 1'b0;
               // current task gone: search every remaining entry
               if (r.proc_id == prev_task)
                  reschedule(at % task_count, task_count);
            end
         end
         OP_TICK, OP_WAIT: begin
            if (r.op == OP_WAIT) begin
               // the idle task never waits; the request then acts as a tick
               if (slot_state[cur] != ST_IDLE) begin
                  slot_state[cur] = ST_WAITING;
                  slot_evt[cur]   = ev;
               end
            end else if (slot_state[cur] == ST_RUNNING) begin
               slot_state[cur] = ST_READY;
            end
            reschedule((cur + 1) % task_count, task_count);
         end
         OP_NOTIFY: begin
            for (int i = 0; i < task_count; i++)
               if (slot_state[i] == ST_WAITING && slot_evt[i] == ev)
                  slot_state[i] = ST_READY;
         end
         default: ;   // undefined op: no change
      endcase
      res.current_id = current_task;
      res.switched   = (current_task != prev_task);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Valid is raised with the payload and held until the
   // transfer; after it, valid stays high unless the next call idles first.
   // The expectation is pushed at the edge of the transfer itself.
   // ---------------------------------------------------------------------
   task automatic send_req(logic [OP_W-1:0] op, logic [ID_W-1:0] pid,
                           logic [EVENT_W-1:0] ev);
      req_type r;
      r.op       = op;
      r.proc_id  = pid;
      r.event_id = ev;
      if (sender_idles && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do
         @(posedge clock);
      while (!req_ready);
      sched_expected.push_back(predict_schedule(r));
   endtask

   // drop valid and hold until every result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (sched_expected.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stall bursts, plus the long hold-off that a test
   // requests through hold_off_cycles, counted down here cycle by cycle.
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            stall_left      = hold_off_cycles;
            hold_off_cycles = 0;
         end else if (stall_left == 0 && receiver_idles && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 17);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // every result transfer is checked against the oldest expectation
   rsp_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (sched_expected.size() == 0) begin
            fail_count++;
            if (mismatch_reports < 10) begin
               mismatch_reports++;
               $display("unexpected result: current %0d switched %0d new %0d error %0d",
                        rsp_payload.current_id, rsp_payload.switched,
                        rsp_payload.new_id, rsp_payload.error);
            end
         end else begin
            want = sched_expected.pop_front();
            if (rsp_payload.current_id !== want.current_id ||
                rsp_payload.switched   !== want.switched   ||
                rsp_payload.new_id     !== want.new_id     ||
                rsp_payload.error      !== want.error) begin
               fail_count++;
               if (mismatch_reports < 10) begin
                  mismatch_reports++;
                  $display("mismatch: expected current %0d switched %0d new %0d error %0d",
                           want.current_id, want.switched, want.new_id, want.error);
                  $display("            actual current %0d switched %0d new %0d error %0d",
                           rsp_payload.current_id, rsp_payload.switched,
                           rsp_payload.new_id, rsp_payload.error);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Hand-picked requests: every op, the idle-end and unknown-id errors, the idle task
   // waiting, end of the current task, undefined op codes.
   task automatic test_directed();
      send_req(OP_TICK, '0, '0);              // only the idle task: stays idle
      send_req(OP_WAIT, '0, 8'hFF);           // idle waits: behaves as a tick
      send_req(OP_NOTIFY, '1, 8'h00);         // nobody waiting
      send_req(OP_END, IDLE_ID, '0);          // idle task cannot end
      send_req(OP_END, '1, 8'hFF);            // unknown id
      for (int k = int'(OP_NOTIFY) + 1; k < 2 ** OP_W; k++)
         send_req(OP_W'(k), '1, '1);          // undefined ops
      repeat (3) send_req(OP_CREATE, '0, '0);
      send_req(OP_TICK, '0, '0);              // idle -> first task
      send_req(OP_WAIT, '0, 8'hFF);           // it waits, next one runs
      send_req(OP_TICK, '0, '0);
      send_req(OP_NOTIFY, '0, 8'hFF);         // waiter ready again
      send_req(OP_TICK, '0, '0);              // round robin wraps to it
      send_req(OP_END, current_task, '0);     // end of the current task
      send_req(OP_END, ID_W'(2), '0);
      send_req(OP_WAIT, '0, 8'h00);
      send_req(OP_END, ID_W'(3), '0);
   endtask

   // fill every slot, then one create too many
   task automatic test_list_full();
      while (task_count < MAX_TASKS)
         send_req(OP_CREATE, ID_W'($urandom), EVENT_W'($urandom));
      send_req(OP_CREATE, '0, '0);
      repeat (4) send_req(OP_TICK, '0, '0);
   endtask

   // Mostly well-formed traffic: ends aim at listed tasks, waits use a small
   // event set and notifies target events that somebody waits on.
   task automatic test_random_mix(int n_items);
      logic [OP_W-1:0]    op;
      logic [ID_W-1:0]    pid;
      logic [EVENT_W-1:0] ev;
      logic [EVENT_W-1:0] waited_evs[$];
      int                 roll;
      for (int k = 0; k < n_items; k++) begin
         pid  = ID_W'($urandom);
         ev   = EVENT_W'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 18) begin
            op = OP_CREATE;
         end else if (roll < 38) begin
            op = OP_END;
            if (task_count > 1 && $urandom_range(0, 2) == 0)
               pid = current_task;
            else if (task_count > 1 && $urandom_range(0, 3) != 0)
               pid = slot_id[$urandom_range(1, task_count - 1)];
         end else if (roll < 62) begin
            op = OP_TICK;
         end else if (roll < 78) begin
            op = OP_WAIT;
            if ($urandom_range(0, 3) != 0)
               ev = event_pool[$urandom_range(0, 3)];
         end else if (roll < 97) begin
            op = OP_NOTIFY;
            waited_evs.delete();
            for (int i = 0; i < task_count; i++)
               if (slot_state[i] == ST_WAITING)
                  waited_evs.push_back(slot_evt[i]);
            if (waited_evs.size() != 0 && $urandom_range(0, 3) != 0)
               ev = waited_evs[$urandom_range(0, waited_evs.size() - 1)];
            else if ($urandom_range(0, 1) == 0)
               ev = event_pool[$urandom_range(0, 3)];
         end else begin
            op = OP_W'($urandom_range(int'(OP_NOTIFY) + 1, 2 ** OP_W - 1));
         end
         send_req(op, pid, ev);
      end
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_output_stall();
      sender_idles    = 1'b0;
      hold_off_cycles = 150;
      test_random_mix(24);
      wait_drained();
      sender_idles = 1'b1;
   endtask

   // bursts separated by full drains of the result channel
   task automatic test_drain_pauses();
      repeat (4) begin
         test_random_mix(10);
         wait_drained();
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------
   initial begin : main_seq
      int drain_cycles;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_payload     <= '0;
      fail_count       = 0;
      mismatch_reports = 0;
      hold_off_cycles  = 0;
      sender_idles     = 1'b1;
      receiver_idles   = 1'b1;
      clear_task_list();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_list_full();
      test_random_mix(150);
      test_output_stall();
      test_drain_pauses();

      // closing stretch at full rate on both sides
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      test_random_mix(150);

      req_valid <= 1'b0;
      drain_cycles = 0;
      while (sched_expected.size() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (40) @(posedge clock);
      fail_count += sched_expected.size();

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin : watchdog
      #(20_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/rrts_pkg.sv
hdl/rrts_task_list.sv
hdl/rrts_sequencer.sv
hdl/round_robin_task_scheduler.sv
tb/round_robin_task_scheduler_tb.sv
